### sv/pfsa_pkg.sv
// Package for the priority focus stack arbiter: sizes, codes, record and
// result types, and the priority and lost-state helper functions. No dependencies.
`timescale 1ns / 1ps
package pfsa_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int ID_WIDTH    = 16;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_REQUEST     = 2'd0,
    CMD_RELEASE     = 2'd1,
    CMD_RELEASE_ALL = 2'd2,
    CMD_UNKNOWN     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_BUSY    = 2'd1,
    STS_FULL    = 2'd2,
    STS_INVALID = 2'd3
  } status_t;

  localparam logic [2:0] FS_NONE           = 3'd0;
  localparam logic [2:0] FS_GRANTED        = 3'd1;
  localparam logic [2:0] FS_TRANSIENT      = 3'd2;
  localparam logic [2:0] FS_DUCK           = 3'd3;
  localparam logic [2:0] FS_LOST           = 3'd4;
  localparam logic [2:0] FS_LOST_TRANSIENT = 3'd5;
  localparam logic [2:0] FS_LOST_DUCK      = 3'd6;

  localparam logic [2:0] TYPE_SPEECH   = 3'd4;
  localparam logic [2:0] TYPE_CALL     = 3'd5;
  localparam logic [2:0] TYPE_MAX      = 3'd5;

  localparam logic [0:0] KIND_NOTICE = 1'b0;
  localparam logic [0:0] KIND_STATUS = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FIND, ST_DECIDE, ST_LIFT, ST_SHIFT, ST_GRANT, ST_EVICT,
    ST_COPY, ST_PUSH, ST_REF_A, ST_REF_B, ST_TYPECHK, ST_STATUS
  } state_t;

  typedef enum logic [1:0] {
    EV_ALL, EV_COPY, EV_PUSH
  } ev_mode_t;

  typedef struct packed {
    logic [ID_WIDTH-1:0] id;
    logic [2:0]          ty;
    logic [1:0]          rq;
    logic [2:0]          st;
  } rec_t;

  typedef struct packed {
    logic        item_kind;
    logic [15:0] notice_id;
    logic [2:0]  notice_type;
    logic [2:0]  notice_state;
    logic [1:0]  status;
    logic        owner_valid;
    logic [15:0] owner_id;
    logic [2:0]  owner_type;
    logic [2:0]  owner_state;
    logic        last;
  } res_t;

  function automatic logic [1:0] prio(input logic [2:0] t);
    if (t == TYPE_CALL)   return 2'd3;
    if (t == TYPE_SPEECH) return 2'd2;
    return 2'd1;
  endfunction

  function automatic logic [2:0] blocked_state(input logic [1:0] rq);
    if (rq == 2'd1) return FS_LOST;
    if (rq == 2'd3) return FS_LOST_DUCK;
    return FS_LOST_TRANSIENT;
  endfunction

endpackage

### sv/pfsa_cmd_if.sv
// Command channel of the focus stack arbiter: valid/ready plus command payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface pfsa_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] client_id;
  logic [2:0]  stream_type;
  logic [2:0]  grant_kind;

  modport source (output valid, cmd, client_id, stream_type, grant_kind, input ready);
  modport sink   (input valid, cmd, client_id, stream_type, grant_kind, output ready);
endinterface

### sv/pfsa_res_if.sv
// Result channel of the focus stack arbiter: notices and command status items.
// Depends on nothing.
`timescale 1ns / 1ps
interface pfsa_res_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [15:0] notice_id;
  logic [2:0]  notice_type;
  logic [2:0]  notice_state;
  logic [1:0]  status;
  logic        owner_valid;
  logic [15:0] owner_id;
  logic [2:0]  owner_type;
  logic [2:0]  owner_state;
  logic        last;

  modport source (output valid, item_kind, notice_id, notice_type, notice_state, status,
                  owner_valid, owner_id, owner_type, owner_state, last, input ready);
  modport sink   (input valid, item_kind, notice_id, notice_type, notice_state, status,
                  owner_valid, owner_id, owner_type, owner_state, last, output ready);
endinterface

### sv/priority_focus_stack_arbiter_core.sv
// Priority focus stack arbiter top level: record stack, sequencer and result register.
// Depends on pfsa_pkg, pfsa_cmd_if and pfsa_res_if.
// Sequence: a command searches the stack, shifts the records above a lifted one down,
// refreshes each record's state (ST_REF_A then ST_REF_B per record), emits a lost notice
// per evicted record and ends with a status item; result stalls hold the sequencer.
// Throughput: one command at a time; the single record read port sets the pace.
// Reset: rst (synchronous, high) empties the stack; record contents stay undefined.
`timescale 1ns / 1ps
module priority_focus_stack_arbiter_core
  import pfsa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  pfsa_cmd_if.sink   req,
  pfsa_res_if.source res
);

  rec_t stack [STACK_DEPTH];

  state_t              state, state_next;
  logic [CNT_W-1:0]    depth_used, depth_used_next;
  logic [CNT_W-1:0]    idx, idx_next;
  cmd_t                cmd_q, cmd_q_next;
  logic [ID_WIDTH-1:0] id_q, id_q_next;
  logic [2:0]          ty_q, ty_q_next;
  logic [2:0]          gr_q, gr_q_next;
  logic [IDX_W-1:0]    pos, pos_next;
  logic                found, found_next;
  logic [2:0]          old_t, old_t_next;
  logic [2:0]          old_s, old_s_next;
  logic [1:0]          req_above, req_above_next;
  logic                above_top, above_top_next;
  logic                chk_type, chk_type_next;
  ev_mode_t            ev_mode, ev_mode_next;
  status_t             status_q, status_q_next;

  res_t             o_item, emit_item;
  logic             o_valid, emit, out_free;
  logic [IDX_W-1:0] ra, wa, top_idx;
  logic             we;
  rec_t             rd, wr_rec;
  logic [2:0]       ns;

  assign rd       = stack[ra];
  assign top_idx  = IDX_W'(depth_used - CNT_W'(1));
  assign out_free = !o_valid || res.ready;
  assign req.ready = (state == ST_IDLE);

  function automatic res_t mk_notice(input rec_t r, input logic [2:0] s);
    res_t n;
    n = '0;
    n.item_kind    = KIND_NOTICE[0];
    n.notice_id    = 16'(r.id);
    n.notice_type  = r.ty;
    n.notice_state = s;
    return n;
  endfunction

  always_comb begin
    state_next      = state;
    depth_used_next = depth_used;
    idx_next        = idx;
    cmd_q_next      = cmd_q;
    id_q_next       = id_q;
    ty_q_next       = ty_q;
    gr_q_next       = gr_q;
    pos_next        = pos;
    found_next      = found;
    old_t_next      = old_t;
    old_s_next      = old_s;
    req_above_next  = req_above;
    above_top_next  = above_top;
    chk_type_next   = chk_type;
    ev_mode_next    = ev_mode;
    status_q_next   = status_q;
    ra        = idx[IDX_W-1:0];
    wa        = idx[IDX_W-1:0];
    we        = 1'b0;
    wr_rec    = rd;
    emit      = 1'b0;
    emit_item = '0;
    ns        = above_top ? {1'b0, rd.rq} : blocked_state(req_above);

    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          cmd_q_next    = cmd_t'(req.cmd);
          id_q_next     = ID_WIDTH'(req.client_id);
          ty_q_next     = req.stream_type;
          gr_q_next     = req.grant_kind;
          status_q_next = STS_OK;
          chk_type_next = 1'b0;
          idx_next      = '0;
          unique case (cmd_t'(req.cmd))
            CMD_REQUEST: begin
              if (req.stream_type > TYPE_MAX || req.grant_kind == 3'd0
                  || req.grant_kind > 3'd3) begin
                status_q_next = STS_INVALID;
                state_next    = ST_STATUS;
              end else begin
                state_next = ST_FIND;
              end
            end
            CMD_RELEASE: state_next = ST_FIND;
            CMD_RELEASE_ALL: begin
              idx_next     = depth_used;
              ev_mode_next = EV_ALL;
              state_next   = ST_EVICT;
            end
            default: begin
              status_q_next = STS_INVALID;
              state_next    = ST_STATUS;
            end
          endcase
        end
      end

      ST_FIND: begin
        if (idx == depth_used) begin
          found_next = 1'b0;
          state_next = (cmd_q == CMD_REQUEST) ? ST_DECIDE : ST_STATUS;
        end else if (rd.id == id_q) begin
          found_next = 1'b1;
          pos_next   = idx[IDX_W-1:0];
          state_next = (cmd_q == CMD_REQUEST) ? ST_DECIDE : ST_LIFT;
        end else begin
          idx_next = idx + CNT_W'(1);
        end
      end

      ST_DECIDE: begin
        ra = top_idx;
        if (found && pos == top_idx) begin
          // owner re-request: update in place, no priority check
          old_t_next    = rd.ty;
          old_s_next    = rd.st;
          we            = 1'b1;
          wa            = top_idx;
          wr_rec.ty     = ty_q;
          wr_rec.rq     = gr_q[1:0];
          chk_type_next = 1'b1;
          if (gr_q == FS_GRANTED && depth_used > CNT_W'(1)) begin
            idx_next     = depth_used - CNT_W'(1);
            ev_mode_next = EV_COPY;
            state_next   = ST_EVICT;
          end else begin
            idx_next   = '0;
            state_next = ST_REF_A;
          end
        end else if (depth_used != '0 && prio(ty_q) < prio(rd.ty)) begin
          status_q_next = STS_BUSY;
          state_next    = ST_STATUS;
        end else if (found) begin
          state_next = ST_LIFT;
        end else begin
          old_t_next = '0;
          old_s_next = FS_NONE;
          state_next = ST_GRANT;
        end
      end

      ST_LIFT: begin
        ra         = pos;
        old_t_next = rd.ty;
        old_s_next = rd.st;
        idx_next   = CNT_W'(pos);
        state_next = ST_SHIFT;
      end

      ST_SHIFT: begin
        if (idx + CNT_W'(1) < depth_used) begin
          // move the record above down by one
          ra       = IDX_W'(idx + CNT_W'(1));
          we       = 1'b1;
          wa       = idx[IDX_W-1:0];
          wr_rec   = rd;
          idx_next = idx + CNT_W'(1);
        end else begin
          depth_used_next = depth_used - CNT_W'(1);
          idx_next        = '0;
          state_next      = (cmd_q == CMD_REQUEST) ? ST_GRANT : ST_REF_A;
        end
      end

      ST_GRANT: begin
        if (gr_q == FS_GRANTED) begin
          idx_next     = depth_used;
          ev_mode_next = EV_PUSH;
          state_next   = ST_EVICT;
        end else if (depth_used >= CNT_W'(STACK_DEPTH)) begin
          status_q_next = STS_FULL;
          state_next    = ST_STATUS;
        end else begin
          state_next = ST_PUSH;
        end
      end

      ST_EVICT: begin
        if (idx == '0) begin
          unique case (ev_mode)
            EV_COPY: state_next = ST_COPY;
            EV_PUSH: begin
              depth_used_next = '0;
              state_next      = ST_PUSH;
            end
            default: begin
              depth_used_next = '0;
              state_next      = ST_STATUS;
            end
          endcase
        end else if (out_free) begin
          ra        = IDX_W'(idx - CNT_W'(1));
          emit      = 1'b1;
          emit_item = mk_notice(rd, FS_LOST);
          idx_next  = idx - CNT_W'(1);
        end
      end

      ST_COPY: begin
        ra              = top_idx;
        we              = 1'b1;
        wa              = '0;
        wr_rec          = rd;
        depth_used_next = CNT_W'(1);
        idx_next        = '0;
        state_next      = ST_REF_A;
      end

      ST_PUSH: begin
        we              = 1'b1;
        wa              = depth_used[IDX_W-1:0];
        wr_rec.id       = id_q;
        wr_rec.ty       = ty_q;
        wr_rec.rq       = gr_q[1:0];
        wr_rec.st       = old_s;
        depth_used_next = depth_used + CNT_W'(1);
        chk_type_next   = 1'b1;
        idx_next        = '0;
        state_next      = ST_REF_A;
      end

      ST_REF_A: begin
        if (idx == depth_used) begin
          state_next = chk_type ? ST_TYPECHK : ST_STATUS;
        end else if (idx + CNT_W'(1) == depth_used) begin
          above_top_next = 1'b1;
          state_next     = ST_REF_B;
        end else begin
          ra             = IDX_W'(idx + CNT_W'(1));
          req_above_next = rd.rq;
          above_top_next = 1'b0;
          state_next     = ST_REF_B;
        end
      end

      ST_REF_B: begin
        if (rd.st != ns) begin
          if (out_free) begin
            we         = 1'b1;
            wr_rec.st  = ns;
            emit       = 1'b1;
            emit_item  = mk_notice(rd, ns);
            idx_next   = idx + CNT_W'(1);
            state_next = ST_REF_A;
          end
        end else begin
          idx_next   = idx + CNT_W'(1);
          state_next = ST_REF_A;
        end
      end

      ST_TYPECHK: begin
        ra = top_idx;
        if (old_s == rd.st && old_t != rd.ty) begin
          // type-only change still gets a notice
          if (out_free) begin
            emit       = 1'b1;
            emit_item  = mk_notice(rd, rd.st);
            state_next = ST_STATUS;
          end
        end else begin
          state_next = ST_STATUS;
        end
      end

      ST_STATUS: begin
        ra = top_idx;
        if (out_free) begin
          emit                = 1'b1;
          emit_item           = '0;
          emit_item.item_kind = KIND_STATUS[0];
          emit_item.status    = status_q;
          emit_item.last      = 1'b1;
          if (depth_used != '0) begin
            emit_item.owner_valid = 1'b1;
            emit_item.owner_id    = 16'(rd.id);
            emit_item.owner_type  = rd.ty;
            emit_item.owner_state = rd.st;
          end
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      depth_used <= '0;
      o_valid    <= 1'b0;
    end else begin
      state      <= state_next;
      depth_used <= depth_used_next;
      if (emit) begin
        o_valid <= 1'b1;
      end else if (res.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    cmd_q     <= cmd_q_next;
    id_q      <= id_q_next;
    ty_q      <= ty_q_next;
    gr_q      <= gr_q_next;
    pos       <= pos_next;
    found     <= found_next;
    old_t     <= old_t_next;
    old_s     <= old_s_next;
    req_above <= req_above_next;
    above_top <= above_top_next;
    chk_type  <= chk_type_next;
    ev_mode   <= ev_mode_next;
    status_q  <= status_q_next;
    if (emit) begin
      o_item <= emit_item;
    end
    if (we) begin
      stack[wa] <= wr_rec;
    end
  end

  assign res.valid        = o_valid;
  assign res.item_kind    = o_item.item_kind;
  assign res.notice_id    = o_item.notice_id;
  assign res.notice_type  = o_item.notice_type;
  assign res.notice_state = o_item.notice_state;
  assign res.status       = o_item.status;
  assign res.owner_valid  = o_item.owner_valid;
  assign res.owner_id     = o_item.owner_id;
  assign res.owner_type   = o_item.owner_type;
  assign res.owner_state  = o_item.owner_state;
  assign res.last         = o_item.last;

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth_used <= CNT_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("command accepted while sequencer busy");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> (o_item.last == o_item.item_kind))
    else $error("last flag does not match status item");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result overwritten before taken");

endmodule
